FILE: src/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define IEE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: %m");

// Checked at every edge, reset included.
`define IEE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed: %m");

`endif

FILE: src/iee_pkg.sv
package iee_pkg;

  localparam int NUM_STACK_DEPTH = 32;
  localparam int OP_STACK_DEPTH  = 32;
  localparam int DATA_WIDTH      = 32;

  localparam int TYPE_W   = 3;
  localparam int IN_W     = 32;
  localparam int STATUS_W = 2;

  typedef logic [TYPE_W-1:0]   tok_type_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [1:0]          tok_cls_t;

  localparam tok_type_t TOK_NUM = 3'd0;
  localparam tok_type_t TOK_LP  = 3'd1;
  localparam tok_type_t TOK_RP  = 3'd2;
  localparam tok_type_t TOK_ADD = 3'd3;
  localparam tok_type_t TOK_SUB = 3'd4;
  localparam tok_type_t TOK_MUL = 3'd5;
  localparam tok_type_t TOK_DIV = 3'd6;
  localparam tok_type_t TOK_END = 3'd7;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_OVF  = 2'd1;
  localparam status_t ST_BAD  = 2'd2;
  localparam status_t ST_DIV0 = 2'd3;

  localparam tok_cls_t CLS_NUM  = 2'd0;
  localparam tok_cls_t CLS_LP   = 2'd1;
  localparam tok_cls_t CLS_SCAN = 2'd2;

  typedef struct packed {
    tok_cls_t  cls;
    tok_type_t req_type;
  } tok_ctl_t;

endpackage

FILE: src/iee_tok_if.sv
interface iee_tok_if;
  import iee_pkg::*;
  logic                   valid;
  logic                   ready;
  tok_type_t              req_type;
  logic signed [IN_W-1:0] number_value;
  modport source(output valid, req_type, number_value, input ready);
  modport sink(input valid, req_type, number_value, output ready);
endinterface

FILE: src/iee_res_if.sv
interface iee_res_if;
  import iee_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] expr_value;
  status_t                status;
  modport source(output valid, expr_value, status, input ready);
  modport sink(input valid, expr_value, status, output ready);
endinterface

FILE: src/iee_front.sv
module iee_front #(
  parameter int DATA_WIDTH = iee_pkg::DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  iee_tok_if.sink               tok,
  output logic                  q_valid,
  input  logic                  q_ready,
  output iee_pkg::tok_ctl_t     q_ctl,
  output logic [DATA_WIDTH-1:0] q_value
);
  import iee_pkg::*;

  tok_ctl_t              ctl_mem [2];
  logic [DATA_WIDTH-1:0] val_mem [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  tok_ctl_t              in_ctl;
  logic                  push;
  logic                  pop;

  always_comb begin
    in_ctl.req_type = tok.req_type;
    unique case (tok.req_type)
      TOK_NUM: in_ctl.cls = CLS_NUM;
      TOK_LP:  in_ctl.cls = CLS_LP;
      default: in_ctl.cls = CLS_SCAN;
    endcase
  end

  assign tok.ready = (count != 2'd2);
  assign q_valid   = (count != 2'd0);
  assign q_ctl     = ctl_mem[rd_ptr];
  assign q_value   = val_mem[rd_ptr];
  assign push      = tok.valid && tok.ready;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_ptr] <= in_ctl;
      val_mem[wr_ptr] <= DATA_WIDTH'(tok.number_value);
    end
  end

endmodule

FILE: src/iee_div.sv
module iee_div #(
  parameter int DATA_WIDTH = iee_pkg::DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient
);
  import iee_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] dvs;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;

  assign shifted  = {rem, quo[DATA_WIDTH-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign ge       = !diff[DATA_WIDTH];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DATA_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo <= {quo[DATA_WIDTH-2:0], ge};
    end
  end

endmodule

FILE: src/iee_back.sv
module iee_back #(
  parameter int NUM_STACK_DEPTH = iee_pkg::NUM_STACK_DEPTH,
  parameter int OP_STACK_DEPTH  = iee_pkg::OP_STACK_DEPTH,
  parameter int DATA_WIDTH      = iee_pkg::DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  iee_pkg::tok_ctl_t     q_ctl,
  input  logic [DATA_WIDTH-1:0] q_value,
  iee_res_if.source             res
);
  import iee_pkg::*;

  localparam int NAW = $clog2(NUM_STACK_DEPTH);
  localparam int NCW = $clog2(NUM_STACK_DEPTH + 1);
  localparam int OAW = $clog2(OP_STACK_DEPTH);
  localparam int OCW = $clog2(OP_STACK_DEPTH + 1);
  localparam int DW  = DATA_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOP = 3'd1;
  localparam logic [2:0] S_RED  = 3'd2;
  localparam logic [2:0] S_DIVW = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_POP  = 3'd5;

  logic [DW-1:0]  nmem [NUM_STACK_DEPTH];
  tok_type_t      omem [OP_STACK_DEPTH];

  logic [2:0]     state, state_next;
  logic [NCW-1:0] n, n_next;
  logic [OCW-1:0] oc, oc_next;
  status_t        err, err_next;
  logic [DW-1:0]  tos, tos_next;
  tok_type_t      optop, optop_next;
  tok_type_t      cur_t, cur_t_next;
  logic [DW-1:0]  res_r, res_r_next;
  logic           qneg, qneg_next;
  logic           out_valid, out_valid_next;
  logic signed [IN_W-1:0] out_value, out_value_next;
  status_t        out_status, out_status_next;

  logic [DW-1:0]  num_rd;
  tok_type_t      op_rd;
  logic [NCW-1:0] n_m2;
  logic [OCW-1:0] oc_m2;

  logic           num_we;
  logic [NAW-1:0] num_wa;
  logic [DW-1:0]  num_wd;
  logic           op_we;
  tok_type_t      op_wd;

  logic           want_red;
  logic           want_push;
  status_t        final_st;
  logic signed [DW-1:0] tos_s;

  logic           div_start;
  logic           div_done;
  logic [DW-1:0]  div_a;
  logic [DW-1:0]  div_b;
  logic [DW-1:0]  div_q;

  assign n_m2  = n - NCW'(2);
  assign oc_m2 = oc - OCW'(2);
  assign tos_s = tos;
  assign div_a = num_rd[DW-1] ? (DW'(0) - num_rd) : num_rd;
  assign div_b = tos[DW-1] ? (DW'(0) - tos) : tos;
  assign final_st = (err == ST_OK && n != NCW'(1)) ? ST_BAD : err;

  assign res.valid      = out_valid;
  assign res.expr_value = out_value;
  assign res.status     = out_status;

  iee_div #(.DATA_WIDTH(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next      = state;
    n_next          = n;
    oc_next         = oc;
    err_next        = err;
    tos_next        = tos;
    optop_next      = optop;
    cur_t_next      = cur_t;
    res_r_next      = res_r;
    qneg_next       = qneg;
    out_valid_next  = out_valid;
    out_value_next  = out_value;
    out_status_next = out_status;
    num_we          = 1'b0;
    num_wa          = n[NAW-1:0];
    num_wd          = q_value;
    op_we           = 1'b0;
    op_wd           = cur_t;
    q_ready         = 1'b0;
    div_start       = 1'b0;
    want_red        = 1'b0;
    want_push       = 1'b0;

    if (res.valid && res.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cur_t_next = q_ctl.req_type;
          if (err == ST_OK || q_ctl.req_type == TOK_END) begin
            unique case (q_ctl.cls)
              CLS_NUM: begin
                if (n >= NCW'(NUM_STACK_DEPTH)) begin
                  err_next = ST_OVF;
                end else begin
                  num_we   = 1'b1;
                  num_wd   = q_value;
                  tos_next = q_value;
                  n_next   = n + NCW'(1);
                end
              end
              CLS_LP: begin
                if (oc >= OCW'(OP_STACK_DEPTH)) begin
                  err_next = ST_OVF;
                end else begin
                  op_we      = 1'b1;
                  op_wd      = TOK_LP;
                  optop_next = TOK_LP;
                  oc_next    = oc + OCW'(1);
                end
              end
              default: state_next = S_LOOP;
            endcase
          end
        end
      end
      S_LOOP: begin
        if (cur_t == TOK_END) begin
          if (err == ST_OK && oc != '0) begin
            if (optop == TOK_LP) begin
              err_next = ST_BAD;
            end else begin
              want_red = 1'b1;
            end
          end else if (!out_valid || res.ready) begin
            out_valid_next  = 1'b1;
            out_status_next = final_st;
            out_value_next  = (final_st == ST_OK) ? IN_W'(tos_s) : '0;
            n_next          = '0;
            oc_next         = '0;
            err_next        = ST_OK;
            state_next      = S_IDLE;
          end
        end else if (err != ST_OK) begin
          state_next = S_IDLE;
        end else begin
          unique case (cur_t)
            TOK_RP: begin
              if (oc == '0) begin
                err_next   = ST_BAD;
                state_next = S_IDLE;
              end else if (optop == TOK_LP) begin
                state_next = S_POP;
              end else begin
                want_red = 1'b1;
              end
            end
            TOK_ADD, TOK_SUB: begin
              if (oc != '0 && optop != TOK_LP) begin
                want_red = 1'b1;
              end else begin
                want_push = 1'b1;
              end
            end
            default: begin
              if (oc != '0 && (optop == TOK_MUL || optop == TOK_DIV)) begin
                want_red = 1'b1;
              end else begin
                want_push = 1'b1;
              end
            end
          endcase
        end
      end
      S_RED: begin
        unique case (optop)
          TOK_ADD: begin
            res_r_next = num_rd + tos;
            state_next = S_WB;
          end
          TOK_SUB: begin
            res_r_next = num_rd - tos;
            state_next = S_WB;
          end
          TOK_MUL: begin
            res_r_next = num_rd * tos;
            state_next = S_WB;
          end
          TOK_DIV: begin
            if (tos == '0) begin
              err_next   = ST_DIV0;
              state_next = S_LOOP;
            end else begin
              div_start  = 1'b1;
              qneg_next  = num_rd[DW-1] ^ tos[DW-1];
              state_next = S_DIVW;
            end
          end
          default: begin
            err_next   = ST_BAD;
            state_next = S_LOOP;
          end
        endcase
      end
      S_DIVW: begin
        if (div_done) begin
          res_r_next = qneg ? (DW'(0) - div_q) : div_q;
          state_next = S_WB;
        end
      end
      S_WB: begin
        num_we     = 1'b1;
        num_wa     = n_m2[NAW-1:0];
        num_wd     = res_r;
        tos_next   = res_r;
        n_next     = n - NCW'(1);
        oc_next    = oc - OCW'(1);
        optop_next = op_rd;
        state_next = S_LOOP;
      end
      S_POP: begin
        oc_next    = oc - OCW'(1);
        optop_next = op_rd;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    if (want_red) begin
      if (n < NCW'(2)) begin
        err_next = ST_BAD;
      end else begin
        state_next = S_RED;
      end
    end

    if (want_push) begin
      state_next = S_IDLE;
      if (oc >= OCW'(OP_STACK_DEPTH)) begin
        err_next = ST_OVF;
      end else begin
        op_we      = 1'b1;
        op_wd      = cur_t;
        optop_next = cur_t;
        oc_next    = oc + OCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      oc        <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      n         <= n_next;
      oc        <= oc_next;
      err       <= err_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    tos        <= tos_next;
    optop      <= optop_next;
    cur_t      <= cur_t_next;
    res_r      <= res_r_next;
    qneg       <= qneg_next;
    out_value  <= out_value_next;
    out_status <= out_status_next;
    num_rd     <= nmem[n_m2[NAW-1:0]];
    op_rd      <= omem[oc_m2[OAW-1:0]];
    if (num_we) begin
      nmem[num_wa] <= num_wd;
    end
    if (op_we) begin
      omem[oc[OAW-1:0]] <= op_wd;
    end
  end

endmodule

FILE: src/infix_expression_evaluator.sv
// Infix expression evaluator with a number stack and an operator stack.
// The tok channel carries one token per transfer: req_type selects a number,
// '(' , ')', '+', '-', '*', '/' or end, and number_value is the operand of a
// number token. The res channel carries one transfer per end token, with the
// expression value and a status (ok, overflow, malformed, divide by zero).
// Tokens enter a two-entry queue and are executed one at a time by a
// sequencer over the two stack memories.
// A number or '(' is pushed by the sequencer straight from its idle state.
// Each reduction passes a reduce and a write-back state, and a / also waits
// between them on the bit-serial divider. Any other token is scanned in a
// loop state plus its reductions, and a ')' pops its '(' in a pop state.
// An end token emits its result from the loop state when no reduction is left.
// Reset empties the queue and both stacks and clears the error; the stack
// memories themselves are not cleared. While res is stalled the result is
// held, and tokens keep flowing until the next end token reaches the point
// of emitting its result.
module infix_expression_evaluator #(
  parameter int NUM_STACK_DEPTH = iee_pkg::NUM_STACK_DEPTH,
  parameter int OP_STACK_DEPTH  = iee_pkg::OP_STACK_DEPTH,
  parameter int DATA_WIDTH      = iee_pkg::DATA_WIDTH
) (
  input logic       clk,
  input logic       rst,
  iee_tok_if.sink   tok,
  iee_res_if.source res
);
  import iee_pkg::*;

  logic                  q_valid;
  logic                  q_ready;
  tok_ctl_t              q_ctl;
  logic [DATA_WIDTH-1:0] q_value;

  iee_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .tok     (tok),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_ctl   (q_ctl),
    .q_value (q_value)
  );

  iee_back #(
    .NUM_STACK_DEPTH (NUM_STACK_DEPTH),
    .OP_STACK_DEPTH  (OP_STACK_DEPTH),
    .DATA_WIDTH      (DATA_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_ctl   (q_ctl),
    .q_value (q_value),
    .res     (res)
  );

endmodule

FILE: src/iee_checker.sv
`include "assert_macros.svh"

module iee_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         tok_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic signed [31:0]           res_expr_value,
  input logic [1:0]                   res_status
);
  import iee_pkg::*;

  `IEE_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid)
  `IEE_ASSERT(a_status_hold, clk, rst, res_valid && !res_ready |=> $stable(res_status))
  `IEE_ASSERT(a_err_zero, clk, rst, res_valid && res_status != ST_OK |-> res_expr_value == 0)
  `IEE_ASSERT_ALWAYS(a_reset_state, clk, $past(rst) && !rst |-> !res_valid && tok_ready)

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
  .clk            (clk),
  .rst            (rst),
  .tok_ready      (tok.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_expr_value (res.expr_value),
  .res_status     (res.status)
);
